@@ hdl/cpts_pkg.sv @@
// shared types and constants of the counter-priority task scheduler
`timescale 1ns / 1ps
package cpts_pkg;

  localparam int unsigned TASK_SLOTS = 16;
  localparam int unsigned IDX_W      = $clog2(TASK_SLOTS);
  localparam int unsigned KCNT_W     = IDX_W + 1;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned WAKE_W     = 32;
  localparam int unsigned SECS_W     = 16;
  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned MS_W       = SECS_W + 10;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_TICK    = 2'd1,
    OP_SLEEP   = 2'd2,
    OP_RESCHED = 2'd3
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_EMPTY    = 2'd0,
    ST_RUNNING  = 2'd1,
    ST_SLEEPING = 2'd2,
    ST_EXITED   = 2'd3
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [PRIO_W-1:0]   prio;
    logic [CNT_W-1:0]    counter;
    logic [WAKE_W-1:0]   wake;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

endpackage

@@ hdl/cpts_table.sv @@
// task table memory, one read and one write port, entries read as zero until written
`timescale 1ns / 1ps
module cpts_table import cpts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output entry_t   rd_data_o
);

  entry_t                mem [TASK_SLOTS];
  logic [TASK_SLOTS-1:0] vld_q;
  entry_t                rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    rd_q <= mem[req_i.rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      rd_vld_q <= vld_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

@@ hdl/counter_priority_task_scheduler_core.sv @@
// counter-priority task scheduler: command sequencer around the task table
//
//  channel  handshake          payload
//  command  start_i / busy_o   op_i, now_ms_i, slot_i, load_status_i,
//                              load_priority_i, load_counter_i, sleep_seconds_i
//  result   done_o (strobe)    switched_o, next_slot_o, stuck_o
//
// a load completes in the idle state; a tick that leaves a nonzero counter ends
// after the current entry is read; a reschedule walks the table once, or twice when
// every running counter is zero, one entry per cycle
// through the single table read port
// reset empties the table at once through per-entry valid bits
// done_o pulses for one cycle and the receiver cannot stall it; busy_o falls
// at the edge that registers the result, and a load never raises it
`timescale 1ns / 1ps
module counter_priority_task_scheduler_core import cpts_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [1:0]        op_i,
  input  logic [WAKE_W-1:0] now_ms_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [ST_W-1:0]   load_status_i,
  input  logic [PRIO_W-1:0] load_priority_i,
  input  logic [CNT_W-1:0]  load_counter_i,
  input  logic [SECS_W-1:0] sleep_seconds_i,
  output logic              done_o,
  output logic              switched_o,
  output logic [SLOT_W-1:0] next_slot_o,
  output logic              stuck_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CUR  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DEC  = 2'd3;

  logic [1:0]        state_q, state_d;
  op_e               op_q, op_d;
  logic [WAKE_W-1:0] now_q, now_d;
  logic [SECS_W-1:0] secs_q, secs_d;
  logic [IDX_W-1:0]  cur_q, cur_d;

  logic [KCNT_W-1:0] k_q, k_d;
  logic              pv_q, pv_d;
  logic [IDX_W-1:0]  pidx_q, pidx_d;
  logic              pass_q, pass_d;
  logic              found_q, found_d;
  logic [CNT_W-1:0]  best_q, best_d;
  logic [IDX_W-1:0]  bidx_q, bidx_d;
  status_e           st0_q, st0_d;

  logic              done_q, done_d;
  logic              sw_q, sw_d;
  logic [IDX_W-1:0]  nslot_q, nslot_d;
  logic              stuck_q, stuck_d;

  mem_req_t          req;
  entry_t            rd;
  entry_t            upd;
  logic [MS_W-1:0]   sleep_ms;
  logic              accept;
  logic              stuck_c;
  logic              pick_ok;
  logic [IDX_W-1:0]  sel;

  cpts_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .rd_data_o (rd)
  );

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign sleep_ms = MS_W'(secs_q) * MS_W'(MS_PER_SEC);

  // scan datapath: wake or refill the entry that came back from the table
  always_comb begin
    upd = rd;
    if (!pass_q) begin
      if (rd.status != ST_EMPTY && rd.status != ST_EXITED && now_q > rd.wake) begin
        upd.status = ST_RUNNING;
      end
    end else if (rd.status != ST_EMPTY) begin
      upd.counter = CNT_W'(rd.prio) + (rd.counter >> 1);
    end
  end

  always_comb begin
    stuck_c = pass_q && found_q && (best_q == '0);
    pick_ok = found_q && !stuck_c;
    sel     = pick_ok ? bidx_q : '0;
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    now_d   = now_q;
    secs_d  = secs_q;
    cur_d   = cur_q;
    k_d     = k_q;
    pv_d    = 1'b0;
    pidx_d  = pidx_q;
    pass_d  = pass_q;
    found_d = found_q;
    best_d  = best_q;
    bidx_d  = bidx_q;
    st0_d   = st0_q;
    done_d  = 1'b0;
    sw_d    = 1'b0;
    nslot_d = cur_q;
    stuck_d = 1'b0;

    req.rd_addr = cur_q;
    req.wr_en   = 1'b0;
    req.wr_addr = cur_q;
    req.wr_data = rd;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d   = op_e'(op_i);
          now_d  = now_ms_i;
          secs_d = sleep_seconds_i;
          if (op_e'(op_i) == OP_LOAD) begin
            if (int'(slot_i) < TASK_SLOTS) begin
              req.wr_en           = 1'b1;
              req.wr_addr         = IDX_W'(slot_i);
              req.wr_data.status  = status_e'(load_status_i);
              req.wr_data.prio    = load_priority_i;
              req.wr_data.counter = load_counter_i;
              req.wr_data.wake    = '0;
            end
            done_d = 1'b1;
          end else begin
            state_d = S_CUR;
          end
        end
      end

      S_CUR: begin
        // current entry is on the read port; prepare the first table walk
        k_d     = '0;
        pass_d  = 1'b0;
        found_d = 1'b0;
        state_d = S_SCAN;
        case (op_q)
          OP_TICK: begin
            req.wr_en = 1'b1;
            if (rd.counter > CNT_W'(1)) begin
              req.wr_data.counter = rd.counter - CNT_W'(1);
              done_d  = 1'b1;
              state_d = S_IDLE;
            end else begin
              req.wr_data.counter = '0;
            end
          end
          OP_SLEEP: begin
            if (rd.status != ST_EMPTY) begin
              req.wr_en          = 1'b1;
              req.wr_data.status = ST_SLEEPING;
              req.wr_data.wake   = now_q + WAKE_W'(sleep_ms);
            end
          end
          default: begin
          end
        endcase
      end

      S_SCAN: begin
        if (int'(k_q) < TASK_SLOTS) begin
          req.rd_addr = k_q[IDX_W-1:0];
          k_d         = k_q + KCNT_W'(1);
          pv_d        = 1'b1;
          pidx_d      = k_q[IDX_W-1:0];
        end
        if (pv_q) begin
          req.wr_en   = 1'b1;
          req.wr_addr = pidx_q;
          req.wr_data = upd;
          if (pidx_q == '0) begin
            st0_d = upd.status;
          end
          if (upd.status == ST_RUNNING && (!found_q || upd.counter > best_q)) begin
            found_d = 1'b1;
            best_d  = upd.counter;
            bidx_d  = pidx_q;
          end
        end else if (int'(k_q) >= TASK_SLOTS) begin
          state_d = S_DEC;
        end
      end

      S_DEC: begin
        if (!pass_q && found_q && best_q == '0) begin
          // every running counter ran out: refill and walk again
          pass_d  = 1'b1;
          k_d     = '0;
          found_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          done_d  = 1'b1;
          stuck_d = stuck_c;
          sw_d    = pick_ok || (st0_q != ST_EMPTY);
          if (pick_ok || (st0_q != ST_EMPTY)) begin
            cur_d   = sel;
            nslot_d = sel;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_q   <= '0;
      pv_q    <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      pv_q    <= pv_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    now_q   <= now_d;
    secs_q  <= secs_d;
    k_q     <= k_d;
    pidx_q  <= pidx_d;
    pass_q  <= pass_d;
    found_q <= found_d;
    best_q  <= best_d;
    bidx_q  <= bidx_d;
    st0_q   <= st0_d;
    sw_q    <= sw_d;
    nslot_q <= nslot_d;
    stuck_q <= stuck_d;
  end

  assign done_o      = done_q;
  assign switched_o  = sw_q;
  assign next_slot_o = SLOT_W'(nslot_q);
  assign stuck_o     = stuck_q;

endmodule

@@ bench/tb_counter_priority_task_scheduler_core.sv @@
// testbench for the counter-priority task scheduler core: directed and random items, self-checking
`timescale 1ns / 1ps
module tb_counter_priority_task_scheduler_core;
  import cpts_pkg::*;

  localparam realtime CLK_PERIOD   = 12.0;
  localparam int      RESET_CYCLES = 9;
  localparam int      N_RANDOM     = 1200;
  localparam int      LIMIT_CYCLES = 400000;
  localparam int      TAIL_CYCLES  = 2 * TASK_SLOTS + 16;
  localparam int      MAX_REPORTS  = 10;

  typedef struct {
    op_e               op;
    logic [WAKE_W-1:0] now;
    logic [SLOT_W-1:0] slot;
    logic [ST_W-1:0]   st;
    logic [PRIO_W-1:0] prio;
    logic [CNT_W-1:0]  cnt;
    logic [SECS_W-1:0] secs;
    bit                hold;
  } sched_cmd_t;

  typedef struct {
    logic              switched;
    logic [SLOT_W-1:0] next_slot;
    logic              stuck;
  } sched_res_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              start_i         = 1'b0;
  logic [1:0]        op_i            = '0;
  logic [WAKE_W-1:0] now_ms_i        = '0;
  logic [SLOT_W-1:0] slot_i          = '0;
  logic [ST_W-1:0]   load_status_i   = '0;
  logic [PRIO_W-1:0] load_priority_i = '0;
  logic [CNT_W-1:0]  load_counter_i  = '0;
  logic [SECS_W-1:0] sleep_seconds_i = '0;
  logic              busy_o;
  logic              done_o;
  logic              switched_o;
  logic [SLOT_W-1:0] next_slot_o;
  logic              stuck_o;

  counter_priority_task_scheduler_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .op_i            (op_i),
    .now_ms_i        (now_ms_i),
    .slot_i          (slot_i),
    .load_status_i   (load_status_i),
    .load_priority_i (load_priority_i),
    .load_counter_i  (load_counter_i),
    .sleep_seconds_i (sleep_seconds_i),
    .done_o          (done_o),
    .switched_o      (switched_o),
    .next_slot_o     (next_slot_o),
    .stuck_o         (stuck_o)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  sched_cmd_t cmd_q[$];
  sched_cmd_t shown_cmd;
  sched_res_t sched_expect_q[$];
  int         outstanding = 0;
  int         fail_cnt    = 0;
  int         cycle_cnt   = 0;
  int         burst_left  = 1;
  int         gap_left    = 0;

  // shadow copy of the task table
  status_e           task_st   [TASK_SLOTS];
  logic [PRIO_W-1:0] task_prio [TASK_SLOTS];
  logic [CNT_W-1:0]  task_cnt  [TASK_SLOTS];
  logic [WAKE_W-1:0] task_wake [TASK_SLOTS];
  logic [SLOT_W-1:0] cur_slot;

  // best running entry; best_cnt is -1 when nothing is running
  function automatic logic [SLOT_W-1:0] pick_best(output int best_cnt);
    logic [SLOT_W-1:0] sel;
    sel      = '0;
    best_cnt = -1;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (task_st[i] == ST_RUNNING && int'(task_cnt[i]) > best_cnt) begin
        best_cnt = int'(task_cnt[i]);
        sel      = SLOT_W'(i);
      end
    end
    return sel;
  endfunction

  function automatic sched_res_t reschedule(logic [WAKE_W-1:0] now);
    sched_res_t        r;
    int                best;
    logic [SLOT_W-1:0] sel;
    r.switched = 1'b0;
    r.stuck    = 1'b0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      if (task_st[i] != ST_EMPTY && task_st[i] != ST_EXITED && now > task_wake[i])
        task_st[i] = ST_RUNNING;
    end
    sel = pick_best(best);
    if (best == 0) begin
      // refill touches exited entries too
      for (int i = 0; i < TASK_SLOTS; i++) begin
        if (task_st[i] != ST_EMPTY)
          task_cnt[i] = CNT_W'(task_prio[i]) + (task_cnt[i] >> 1);
      end
      sel = pick_best(best);
      if (best == 0) begin
        r.stuck = 1'b1;
        sel     = '0;
      end
    end
    if (task_st[sel] != ST_EMPTY) begin
      cur_slot   = sel;
      r.switched = 1'b1;
    end
    r.next_slot = cur_slot;
    return r;
  endfunction

  function automatic sched_res_t schedule_item(sched_cmd_t c);
    sched_res_t r;
    r.switched  = 1'b0;
    r.next_slot = cur_slot;
    r.stuck     = 1'b0;
    case (c.op)
      OP_LOAD: begin
        task_st[c.slot]   = status_e'(c.st);
        task_prio[c.slot] = c.prio;
        task_cnt[c.slot]  = c.cnt;
        task_wake[c.slot] = '0;
      end
      OP_TICK: begin
        if (task_cnt[cur_slot] > 1) begin
          task_cnt[cur_slot] = task_cnt[cur_slot] - 1'b1;
        end else begin
          task_cnt[cur_slot] = '0;
          r = reschedule(c.now);
        end
      end
      OP_SLEEP: begin
        if (task_st[cur_slot] != ST_EMPTY) begin
          task_wake[cur_slot] = c.now + WAKE_W'(MS_PER_SEC) * WAKE_W'(c.secs);
          task_st[cur_slot]   = ST_SLEEPING;
        end
        r = reschedule(c.now);
      end
      default: r = reschedule(c.now);
    endcase
    return r;
  endfunction

  task automatic report_fail(string what);
    if (fail_cnt < MAX_REPORTS)
      $display("[%0t] %s", $realtime, what);
    fail_cnt++;
  endtask

  task automatic add_cmd(op_e op, logic [WAKE_W-1:0] now, logic [SLOT_W-1:0] slot,
                         status_e st, logic [PRIO_W-1:0] prio, logic [CNT_W-1:0] cnt,
                         logic [SECS_W-1:0] secs, bit hold);
    sched_cmd_t c;
    c.op   = op;
    c.now  = now;
    c.slot = slot;
    c.st   = st;
    c.prio = prio;
    c.cnt  = cnt;
    c.secs = secs;
    c.hold = hold;
    cmd_q.push_back(c);
  endtask

  // driver: bursts of items separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    bit         taken;
    sched_cmd_t nxt;
    if (!rst_ni) begin
      start_i    <= 1'b0;
      op_i       <= OP_LOAD;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      taken = start_i && !busy_o;
      if (!start_i || taken) begin
        if (taken) begin
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
        if (gap_left > 0) begin
          gap_left--;
          start_i <= 1'b0;
        end else if (cmd_q.size() > 0 &&
                     (!cmd_q[0].hold || (outstanding == 0 && !taken))) begin
          nxt = cmd_q.pop_front();
          start_i         <= 1'b1;
          op_i            <= nxt.op;
          now_ms_i        <= nxt.now;
          slot_i          <= nxt.slot;
          load_status_i   <= nxt.st;
          load_priority_i <= nxt.prio;
          load_counter_i  <= nxt.cnt;
          sleep_seconds_i <= nxt.secs;
          shown_cmd       <= nxt;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result, then predicts the item taken at this edge
  always @(posedge clk_i or negedge rst_ni) begin
    sched_res_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        task_st[i]   = ST_EMPTY;
        task_prio[i] = '0;
        task_cnt[i]  = '0;
        task_wake[i] = '0;
      end
      cur_slot = '0;
      sched_expect_q.delete();
      outstanding <= 0;
    end else begin
      if (done_o) begin
        if (sched_expect_q.size() == 0) begin
          report_fail($sformatf("result with no item outstanding: switched %0d slot %0d stuck %0d",
                                switched_o, next_slot_o, stuck_o));
        end else begin
          want = sched_expect_q.pop_front();
          if (switched_o !== want.switched || next_slot_o !== want.next_slot ||
              stuck_o !== want.stuck)
            report_fail($sformatf({"mismatch: exp switched %0d slot %0d stuck %0d,",
                                   " got switched %0d slot %0d stuck %0d"},
                                  want.switched, want.next_slot, want.stuck,
                                  switched_o, next_slot_o, stuck_o));
        end
      end
      if (start_i && !busy_o)
        sched_expect_q.push_back(schedule_item(shown_cmd));
      outstanding <= sched_expect_q.size();
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("tb_counter_priority_task_scheduler_core: done, errors");
      $finish;
    end
  end

  initial begin
    logic [WAKE_W-1:0] clock_ms;
    int                pick;
    bit                wild;
    op_e               op;
    status_e           st;

    // directed part
    add_cmd(OP_RESCHED, 32'd0, 4'd0, ST_EMPTY, 8'd0, 9'd0, 16'd0, 1'b0);
    add_cmd(OP_TICK, 32'd5, 4'd0, ST_EMPTY, 8'd0, 9'd0, 16'd0, 1'b0);
    // sleep with an empty current entry
    add_cmd(OP_SLEEP, 32'hFFFF_FFFF, 4'd0, ST_EMPTY, 8'd0, 9'd0, 16'hFFFF, 1'b0);
    add_cmd(OP_LOAD, 32'd0, 4'd0, ST_RUNNING, 8'd0, 9'd0, 16'd0, 1'b0);
    add_cmd(OP_LOAD, 32'd0, 4'd15, ST_RUNNING, 8'd0, 9'd1, 16'd0, 1'b0);
    add_cmd(OP_RESCHED, 32'd1, 4'd0, ST_EMPTY, 8'd0, 9'd0, 16'd0, 1'b0);
    // tick to zero, refill leaves everything zero
    add_cmd(OP_TICK, 32'd2, 4'd0, ST_EMPTY, 8'd0, 9'd0, 16'd0, 1'b0);
    add_cmd(OP_LOAD, 32'd0, 4'd0, ST_EMPTY, 8'hFF, 9'h1FF, 16'd0, 1'b0);
    // stuck with slot 0 empty
    add_cmd(OP_RESCHED, 32'd3, 4'd0, ST_EMPTY, 8'd0, 9'd0, 16'd0, 1'b0);
    add_cmd(OP_LOAD, 32'd0, 4'd7, ST_EXITED, 8'd200, 9'd0, 16'd0, 1'b0);
    add_cmd(OP_LOAD, 32'd0, 4'd3, ST_SLEEPING, 8'hFF, 9'h1FF, 16'd0, 1'b0);
    add_cmd(OP_RESCHED, 32'd0, 4'd0, ST_EMPTY, 8'd0, 9'd0, 16'd0, 1'b0);
    add_cmd(OP_RESCHED, 32'd10, 4'd0, ST_EMPTY, 8'd0, 9'd0, 16'd0, 1'b0);
    add_cmd(OP_TICK, 32'd11, 4'd0, ST_EMPTY, 8'd0, 9'd0, 16'd0, 1'b0);
    add_cmd(OP_LOAD, 32'd0, 4'd8, ST_RUNNING, 8'hFF, 9'h1FF, 16'd0, 1'b0);
    // wake time wraps past 2^32
    add_cmd(OP_SLEEP, 32'hFFFF_FF00, 4'd0, ST_EMPTY, 8'd0, 9'd0, 16'hFFFF, 1'b1);
    add_cmd(OP_LOAD, 32'd0, 4'd9, ST_RUNNING, 8'hFF, 9'h1FF, 16'd0, 1'b0);
    add_cmd(OP_RESCHED, 32'd20, 4'd0, ST_EMPTY, 8'd0, 9'd0, 16'd0, 1'b0);
    add_cmd(OP_SLEEP, 32'd30, 4'd0, ST_EMPTY, 8'd0, 9'd0, 16'd1, 1'b0);
    add_cmd(OP_RESCHED, 32'd1031, 4'd0, ST_EMPTY, 8'd0, 9'd0, 16'd0, 1'b0);
    add_cmd(OP_RESCHED, 32'hFFFF_FFFF, 4'd0, ST_EMPTY, 8'd0, 9'd0, 16'd0, 1'b0);

    // random part: mostly small counters and short sleeps so refills and wake-ups happen
    clock_ms = 32'd2000;
    for (int n = 0; n < N_RANDOM; n++) begin
      wild = ($urandom_range(0, 15) == 0);
      if ($urandom_range(0, 19) == 0)
        clock_ms = $urandom();
      else
        clock_ms = clock_ms + $urandom_range(0, 1500);
      pick = $urandom_range(0, 99);
      op = (pick < 22) ? OP_LOAD : (pick < 60) ? OP_TICK : (pick < 72) ? OP_SLEEP : OP_RESCHED;
      pick = $urandom_range(0, 9);
      if (wild)
        st = status_e'($urandom_range(0, 3));
      else
        st = (pick < 6) ? ST_RUNNING : (pick < 8) ? ST_SLEEPING : (pick < 9) ? ST_EXITED : ST_EMPTY;
      add_cmd(op, clock_ms, SLOT_W'($urandom_range(0, 15)), st,
              PRIO_W'(wild ? $urandom_range(0, 255) : $urandom_range(0, 6)),
              CNT_W'(wild ? $urandom_range(0, 511) : $urandom_range(0, 12)),
              SECS_W'(wild ? $urandom_range(0, 65535) : $urandom_range(0, 3)),
              (n == 0) || ($urandom_range(0, 49) == 0));
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sampled on the falling edge so that every update of the rising edge has settled
    while (cmd_q.size() != 0 || start_i || outstanding != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (fail_cnt == 0 && outstanding == 0) begin
      $display("tb_counter_priority_task_scheduler_core: done, clean");
    end else begin
      $display("tb_counter_priority_task_scheduler_core: done, errors");
    end
    $finish;
  end

endmodule
